### rtl/utf8ws_pkg.sv
// ----------------------------------------------------------------------------
// utf8ws_pkg
// Shared types for the UTF-8 word splitter: result kinds and the per-item
// burst descriptor passed from the decoder to the output sequencer.
// ----------------------------------------------------------------------------
package utf8ws_pkg;

  localparam int unsigned CodeW  = 21;  // code point width
  localparam int unsigned CountW = 3;   // holds 0..6 results per item

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_TEXT_END  = 2'd2
  } kind_e;

  // What follows the token bytes of one item
  typedef enum logic [1:0] {
    TAIL_NONE      = 2'd0,
    TAIL_TOKEN_END = 2'd1,
    TAIL_TEXT_END  = 2'd2
  } tail_e;

  // Results of one input item, in order:
  // optional token end, 0..4 token bytes, optional tail mark.
  typedef struct packed {
    logic              pre_close;
    logic [2:0]        byte_cnt;
    logic [3:0][7:0]   bytes;
    tail_e             tail;
  } burst_t;

endpackage

### rtl/utf8ws_if.sv
// ----------------------------------------------------------------------------
// utf8ws_in_if / utf8ws_out_if
// Valid/ready channels for text bytes in and token results out.
// ----------------------------------------------------------------------------
interface utf8ws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf8ws_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/utf8_word_splitter_core.sv
// ----------------------------------------------------------------------------
// utf8_word_splitter_core
// UTF-8 byte stream to word tokens: decode, classify, re-encode kept
// characters and emit token bytes, token-end and text-end marks.
// ----------------------------------------------------------------------------
//  channel | dir | payload                    | accepted when
//  in_i    | in  | in_byte, end_of_text       | in_i.valid & in_i.ready
//  out_o   | out | kind, out_byte, last       | out_o.valid & out_o.ready
//
//  An item is decoded in the cycle it is accepted; its 0..6 results go to a
//  burst register and leave through the output register one per cycle
//  while the output is not stalled. A new item is accepted only once the
//  burst register is empty or its last result moves to the output register.
//  Reset (async, active low) clears decoder state and closes any word.
//  Output stalls back up into the burst register, then into in_i.ready.
// ----------------------------------------------------------------------------
module utf8_word_splitter_core
  import utf8ws_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8ws_in_if.sink    in_i,
  utf8ws_out_if.source out_o
);

  // --- decode ---------------------------------------------------------------
  logic   in_acc;
  burst_t burst_d;

  assign in_acc = in_i.valid & in_i.ready;

  utf8ws_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .in_byte_i     (in_i.in_byte),
    .end_of_text_i (in_i.end_of_text),
    .burst_o       (burst_d)
  );

  // number of results for the incoming item
  logic [CountW-1:0] total_d;
  assign total_d = {2'd0, burst_d.pre_close} + burst_d.byte_cnt
                 + {2'd0, (burst_d.tail != TAIL_NONE)};

  // --- burst register -------------------------------------------------------
  burst_t            burst_q;
  logic              burst_vq;
  logic [CountW-1:0] pos_q;
  logic [CountW-1:0] total_q;

  logic out_vq;
  logic out_free;   // output register can take an item this cycle
  logic move;       // burst head moves to output register
  logic burst_done; // last result of the burst moves

  assign out_free   = !out_vq | out_o.ready;
  assign move       = burst_vq & out_free;
  assign burst_done = move & (pos_q == total_q - 3'd1);
  assign in_i.ready = !burst_vq | burst_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_vq <= 1'b0;
      pos_q    <= '0;
      total_q  <= '0;
    end else if (in_acc) begin
      burst_vq <= (total_d != '0);
      pos_q    <= '0;
      total_q  <= total_d;
    end else if (burst_done) begin
      burst_vq <= 1'b0;
    end else if (move) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      burst_q <= burst_d;
    end
  end

  // --- pick the result at pos_q ---------------------------------------------
  kind_e             sel_kind;
  logic [7:0]        sel_byte;
  logic [CountW-1:0] byte_pos;

  assign byte_pos = pos_q - {2'd0, burst_q.pre_close};

  always_comb begin
    sel_byte = '0;
    if (burst_q.pre_close && pos_q == '0) begin
      sel_kind = KIND_TOKEN_END;
    end else if (byte_pos < burst_q.byte_cnt) begin
      sel_kind = KIND_BYTE;
      sel_byte = burst_q.bytes[byte_pos[1:0]];
    end else begin
      case (burst_q.tail)
        TAIL_TEXT_END: sel_kind = KIND_TEXT_END;
        default:       sel_kind = KIND_TOKEN_END;
      endcase
    end
  end

  // --- output register ------------------------------------------------------
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_free) begin
      out_vq <= move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q <= sel_kind;
      out_byte_q <= sel_byte;
      out_last_q <= (pos_q == total_q - 3'd1);
    end
  end

  assign out_o.valid    = out_vq;
  assign out_o.kind     = out_kind_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTHESIS
  a_burst_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_vq |-> (total_q != '0 && pos_q < total_q))
    else $error("burst position out of range");

  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_kind_q != KIND_BYTE) |-> (out_byte_q == '0))
    else $error("mark item carries a nonzero byte");

  a_text_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_kind_q == KIND_TEXT_END) |-> out_last_q)
    else $error("text end is not the last result");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && !burst_done) |=> (burst_vq && pos_q == $past(pos_q) + 3'd1))
    else $error("burst lost before its last result");
`endif

endmodule

### rtl/utf8ws_decode.sv
// ----------------------------------------------------------------------------
// utf8ws_decode
// Streaming UTF-8 decoder and classifier. Holds decoder and word state and
// turns one accepted item into a burst descriptor in the same cycle.
// ----------------------------------------------------------------------------
module utf8ws_decode
  import utf8ws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output burst_t     burst_o
);

  logic [CodeW-1:0] partial_q, partial_d;
  logic [1:0]       need_q, need_d;
  logic             word_open_q, word_open_d;

  function automatic logic is_cjk(input logic [CodeW-1:0] c);
    is_cjk = (c >= 21'h04E00 && c <= 21'h09FFF) ||
             (c >= 21'h03400 && c <= 21'h04DBF) ||
             (c >= 21'h20000 && c <= 21'h2A6DF) ||
             (c >= 21'h2A700 && c <= 21'h2CEAF) ||
             (c >= 21'h0F900 && c <= 21'h0FAFF) ||
             (c >= 21'h2F800 && c <= 21'h2FA1F);
  endfunction

  function automatic logic is_space(input logic [CodeW-1:0] c);
    is_space = c == 21'h20 || (c >= 21'h09 && c <= 21'h0D) || c == 21'hA0 ||
               c == 21'h3000 || (c >= 21'h2000 && c <= 21'h200A);
  endfunction

  function automatic logic is_kept(input logic [CodeW-1:0] c);
    is_kept = c == 21'h27 ||
              (c >= 21'h30 && c <= 21'h39) ||
              (c >= 21'h41 && c <= 21'h5A) ||
              (c >= 21'h61 && c <= 21'h7A) ||
              (c >= 21'h00C0 && c <= 21'h024F) ||
              (c >= 21'h0370 && c <= 21'h04FF) ||
              (c >= 21'h3040 && c <= 21'h30FF) ||
              (c >= 21'hAC00 && c <= 21'hD7A3) ||
              (c >= 21'hFF10 && c <= 21'hFF19) ||
              (c >= 21'hFF21 && c <= 21'hFF3A) ||
              (c >= 21'hFF41 && c <= 21'hFF5A);
  endfunction

  logic             as_lead;
  logic             have_code;
  logic [CodeW-1:0] code;
  logic [CodeW-1:0] cont_code;
  logic [2:0]       enc_cnt;
  logic [3:0][7:0]  enc_bytes;

  assign cont_code = {partial_q[CodeW-7:0], in_byte_i[5:0]};

  // UTF-8 re-encode of the completed code point
  always_comb begin
    enc_bytes = '0;
    if (code < 21'h80) begin
      enc_cnt      = 3'd1;
      enc_bytes[0] = code[7:0];
    end else if (code < 21'h800) begin
      enc_cnt      = 3'd2;
      enc_bytes[0] = {3'b110, code[10:6]};
      enc_bytes[1] = {2'b10, code[5:0]};
    end else if (code < 21'h10000) begin
      enc_cnt      = 3'd3;
      enc_bytes[0] = {4'b1110, code[15:12]};
      enc_bytes[1] = {2'b10, code[11:6]};
      enc_bytes[2] = {2'b10, code[5:0]};
    end else begin
      enc_cnt      = 3'd4;
      enc_bytes[0] = {5'b11110, code[20:18]};
      enc_bytes[1] = {2'b10, code[17:12]};
      enc_bytes[2] = {2'b10, code[11:6]};
      enc_bytes[3] = {2'b10, code[5:0]};
    end
  end

  always_comb begin
    partial_d   = partial_q;
    need_d      = need_q;
    word_open_d = word_open_q;
    burst_o     = '0;
    as_lead     = 1'b1;
    have_code   = 1'b0;
    code        = '0;

    if (end_of_text_i) begin
      partial_d         = '0;
      need_d            = '0;
      word_open_d       = 1'b0;
      burst_o.pre_close = word_open_q;
      burst_o.tail      = TAIL_TEXT_END;
    end else begin
      if (need_q != 2'd0) begin
        if (in_byte_i[7:6] == 2'b10) begin
          as_lead   = 1'b0;
          partial_d = cont_code;
          need_d    = need_q - 2'd1;
          if (need_q == 2'd1) begin
            have_code = 1'b1;
            code      = cont_code;
          end
        end else begin
          // broken sequence: drop it, reuse the byte as a lead
          partial_d = '0;
          need_d    = '0;
        end
      end
      if (as_lead) begin
        if (!in_byte_i[7]) begin
          have_code = 1'b1;
          code      = {13'd0, in_byte_i};
        end else if (in_byte_i[7:5] == 3'b110) begin
          partial_d = {16'd0, in_byte_i[4:0]};
          need_d    = 2'd1;
        end else if (in_byte_i[7:4] == 4'b1110) begin
          partial_d = {17'd0, in_byte_i[3:0]};
          need_d    = 2'd2;
        end else if (in_byte_i[7:3] == 5'b11110) begin
          partial_d = {18'd0, in_byte_i[2:0]};
          need_d    = 2'd3;
        end
      end
      if (have_code) begin
        if (is_cjk(code)) begin
          burst_o.pre_close = word_open_q;
          burst_o.byte_cnt  = enc_cnt;
          burst_o.bytes     = enc_bytes;
          burst_o.tail      = TAIL_TOKEN_END;
          word_open_d       = 1'b0;
        end else if (is_space(code)) begin
          burst_o.pre_close = word_open_q;
          word_open_d       = 1'b0;
        end else if (is_kept(code)) begin
          burst_o.byte_cnt  = enc_cnt;
          burst_o.bytes     = enc_bytes;
          word_open_d       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      need_q      <= '0;
      word_open_q <= 1'b0;
    end else if (accept_i) begin
      partial_q   <= partial_d;
      need_q      <= need_d;
      word_open_q <= word_open_d;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: utf8_word_splitter_core testbench
// Streams UTF-8 text into the splitter: directed words, multi-byte and
// malformed sequences, then random text under four pacing phases. A local
// decoder/tokenizer predicts every result item and a checker compares each
// accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import utf8ws_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 20;    // extra wait for unexpected results after the queue empties
  localparam int PRINT_CAP      = 50;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } token_res_t;

  logic clk_i;
  logic rst_ni;

  utf8ws_in_if  in_if ();
  utf8ws_out_if out_if ();

  utf8_word_splitter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Pacing knobs, percent per cycle
  int idle_pct  = 0;
  int stall_pct = 0;

  int err_cnt     = 0;
  int items_sent  = 0;
  int res_checked = 0;
  int quiet_cycles = 0;

  // Predicted token results, oldest first
  token_res_t token_q[$];

  // Local copy of the decoder state
  logic [20:0] dec_code  = '0;
  logic [1:0]  dec_need  = '0;
  logic        word_open = 1'b0;

  // Results of the item being predicted
  token_res_t step_res[6];
  int         step_cnt;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Character classes and UTF-8 encoding
  // --------------------------------------------------------------------------
  function automatic bit is_ideograph(input logic [20:0] c);
    return (c >= 21'h4E00  && c <= 21'h9FFF)  ||
           (c >= 21'h3400  && c <= 21'h4DBF)  ||
           (c >= 21'h20000 && c <= 21'h2A6DF) ||
           (c >= 21'h2A700 && c <= 21'h2CEAF) ||
           (c >= 21'hF900  && c <= 21'hFAFF)  ||
           (c >= 21'h2F800 && c <= 21'h2FA1F);
  endfunction

  function automatic bit is_blank(input logic [20:0] c);
    return c == 21'h20 || (c >= 21'h09 && c <= 21'h0D) || c == 21'hA0 ||
           c == 21'h3000 || (c >= 21'h2000 && c <= 21'h200A);
  endfunction

  function automatic bit is_word_char(input logic [20:0] c);
    return c == 21'h27 ||
           (c >= 21'h30   && c <= 21'h39)   ||
           (c >= 21'h41   && c <= 21'h5A)   ||
           (c >= 21'h61   && c <= 21'h7A)   ||
           (c >= 21'h00C0 && c <= 21'h024F) ||
           (c >= 21'h0370 && c <= 21'h04FF) ||
           (c >= 21'h3040 && c <= 21'h30FF) ||
           (c >= 21'hAC00 && c <= 21'hD7A3) ||
           (c >= 21'hFF10 && c <= 21'hFF19) ||
           (c >= 21'hFF21 && c <= 21'hFF3A) ||
           (c >= 21'hFF41 && c <= 21'hFF5A) ||
           is_ideograph(c);
  endfunction

  function automatic int utf8_len(input logic [20:0] cp);
    if (cp < 21'h80)    return 1;
    if (cp < 21'h800)   return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Byte i of the sequence sits at [8*i +: 8]
  function automatic logic [31:0] utf8_bytes(input logic [20:0] cp);
    logic [31:0] s;
    s = '0;
    case (utf8_len(cp))
      1: s[7:0] = cp[7:0];
      2: begin
        s[7:0]   = {3'b110, cp[10:6]};
        s[15:8]  = {2'b10, cp[5:0]};
      end
      3: begin
        s[7:0]   = {4'b1110, cp[15:12]};
        s[15:8]  = {2'b10, cp[11:6]};
        s[23:16] = {2'b10, cp[5:0]};
      end
      default: begin
        s[7:0]   = {5'b11110, cp[20:18]};
        s[15:8]  = {2'b10, cp[17:12]};
        s[23:16] = {2'b10, cp[11:6]};
        s[31:24] = {2'b10, cp[5:0]};
      end
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Token predictor
  // --------------------------------------------------------------------------
  function automatic void emit(input kind_e k, input logic [7:0] d);
    token_res_t r;
    r.kind = k;
    r.data = d;
    r.last = 1'b0;
    step_res[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void emit_code(input logic [20:0] cp);
    logic [31:0] s;
    s = utf8_bytes(cp);
    for (int i = 0; i < utf8_len(cp); i++) emit(KIND_BYTE, s[8*i +: 8]);
  endfunction

  function automatic void end_word();
    if (word_open) begin
      emit(KIND_TOKEN_END, 8'h00);
      word_open = 1'b0;
    end
  endfunction

  function automatic void take_code(input logic [20:0] c);
    if (is_ideograph(c)) begin
      // ideograph is a one-character token of its own
      end_word();
      emit_code(c);
      emit(KIND_TOKEN_END, 8'h00);
    end else if (is_blank(c)) begin
      end_word();
    end else if (is_word_char(c)) begin
      emit_code(c);
      word_open = 1'b1;
    end
  endfunction

  function automatic void predict_tokens(input logic [7:0] b, input logic eot);
    logic       as_lead;
    token_res_t r;
    step_cnt = 0;
    as_lead  = 1'b1;
    if (eot) begin
      // pending bytes dropped, open word closed
      dec_code = '0;
      dec_need = '0;
      end_word();
      emit(KIND_TEXT_END, 8'h00);
    end else begin
      if (dec_need != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          as_lead  = 1'b0;
          dec_code = {dec_code[14:0], b[5:0]};
          dec_need = dec_need - 2'd1;
          if (dec_need == 2'd0) take_code(dec_code);
        end else begin
          // bad continuation: drop the pending lead, reuse byte as a lead
          dec_code = '0;
          dec_need = '0;
        end
      end
      if (as_lead) begin
        if (b[7] == 1'b0) begin
          take_code({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
          dec_code = {16'd0, b[4:0]};
          dec_need = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          dec_code = {17'd0, b[3:0]};
          dec_need = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          dec_code = {18'd0, b[2:0]};
          dec_need = 2'd3;
        end
        // anything else is an invalid lead and is skipped
      end
    end
    for (int i = 0; i < step_cnt; i++) begin
      r = step_res[i];
      r.last = (i == step_cnt - 1);
      token_q.insert(token_q.size(), r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one item per call, valid stays high into the next call
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eot);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= b;
    in_if.end_of_text <= eot;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predict_tokens(b, eot);
    items_sent++;
  endtask

  task automatic send_code(input logic [20:0] cp);
    logic [31:0] s;
    s = utf8_bytes(cp);
    for (int i = 0; i < utf8_len(cp); i++) send_item(s[8*i +: 8], 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls and the result checker
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    token_res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      res_checked++;
      if (token_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
          $display("%0t: unexpected result: expected none, ", $realtime,
                   "got kind=%0d byte=%02h last=%0d",
                   out_if.kind, out_if.out_byte, out_if.last);
      end else begin
        want = token_q.pop_front();
        if (out_if.kind !== want.kind || out_if.out_byte !== want.data ||
            out_if.last !== want.last) begin
          err_cnt++;
          if (err_cnt <= PRINT_CAP)
            $display("%0t: result mismatch: ", $realtime,
                     "expected kind=%0d byte=%02h last=%0d, ",
                     want.kind, want.data, want.last,
                     "got kind=%0d byte=%02h last=%0d",
                     out_if.kind, out_if.out_byte, out_if.last);
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: watchdog: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // ASCII word chars, byte extremes, space closing a word, end of text
  // with no word open (byte field ignored there)
  task automatic test_ascii_words();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(8'h41, 1'b0);  // 'A' opens a word
    send_item(8'h27, 1'b0);  // apostrophe kept
    send_item(8'h00, 1'b0);  // dropped, word stays open
    send_item(8'h7A, 1'b0);
    send_item(8'h7F, 1'b0);  // dropped
    send_item(8'h30, 1'b0);
    send_item(8'h20, 1'b0);  // closes the word
    send_item(8'hFF, 1'b1);  // only a text-end mark
  endtask

  // Two-byte Latin, four-byte ideograph right after an open word (largest
  // burst: token end, four bytes, token end), ideographic space, no word open
  task automatic test_multibyte_chars();
    stall_pct = 50;
    send_code(21'h00C0);
    send_code(21'h20000);
    send_code(21'h3000);
  endtask

  // Stray continuation, invalid lead, bad continuation reused as a lead,
  // overlong form decoded leniently, truncated sequence at end of text
  task automatic test_malformed_input();
    stall_pct = 0;
    idle_pct  = 50;
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h41, 1'b0);  // drops the C3, 'A' opens a word
    send_item(8'hC1, 1'b0);
    send_item(8'h81, 1'b0);  // overlong 'A', appended
    send_item(8'hE4, 1'b0);
    send_item(8'hB8, 1'b0);
    send_item(8'h00, 1'b1);  // truncated ideograph dropped, word closed
  endtask

  // Value in [lo, hi], with the edges and just outside them now and then
  function automatic logic [20:0] range_pick(input logic [20:0] lo, input logic [20:0] hi);
    case ($urandom_range(0, 7))
      0:       return lo - 21'd1;
      1:       return lo;
      2:       return hi;
      3:       return hi + 21'd1;
      default: return lo + 21'($urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  function automatic logic [20:0] pick_code();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 3))
          0:       return 21'h61 + 21'($urandom_range(0, 25));
          1:       return 21'h41 + 21'($urandom_range(0, 25));
          2:       return 21'h30 + 21'($urandom_range(0, 9));
          default: return 21'h27;
        endcase
      end
      3: begin
        case ($urandom_range(0, 4))
          0:       return 21'h20;
          1:       return range_pick(21'h09, 21'h0D);
          2:       return 21'hA0;
          3:       return 21'h3000;
          default: return range_pick(21'h2000, 21'h200A);
        endcase
      end
      4: return 21'($urandom_range(0, 127));
      5, 6: begin
        case ($urandom_range(0, 6))
          0:       return range_pick(21'h00C0, 21'h024F);
          1:       return range_pick(21'h0370, 21'h04FF);
          2:       return range_pick(21'h3040, 21'h30FF);
          3:       return range_pick(21'hAC00, 21'hD7A3);
          4:       return range_pick(21'hFF10, 21'hFF19);
          5:       return range_pick(21'hFF21, 21'hFF3A);
          default: return range_pick(21'hFF41, 21'hFF5A);
        endcase
      end
      7: begin
        case ($urandom_range(0, 5))
          0:       return range_pick(21'h4E00, 21'h9FFF);
          1:       return range_pick(21'h3400, 21'h4DBF);
          2:       return range_pick(21'h20000, 21'h2A6DF);
          3:       return range_pick(21'h2A700, 21'h2CEAF);
          4:       return range_pick(21'hF900, 21'hFAFF);
          default: return range_pick(21'h2F800, 21'h2FA1F);
        endcase
      end
      default: return 21'($urandom_range(0, 21'h1FFFFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    case (len)
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Mostly well-formed characters with random content; the rest raw lenient
  // sequences, broken sequences, noise bytes and end-of-text marks.
  // Noise bytes are not counted toward the item budget.
  task automatic random_text(input int n_items);
    int          cnt;
    int          len;
    int          k;
    logic [20:0] cp;
    logic [7:0]  b;
    cnt = 0;
    while (cnt < n_items) begin
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          cp = pick_code();
          send_code(cp);
          cnt += utf8_len(cp);
        end
        [60:69]: begin
          // raw lead and continuations: overlongs, surrogates, > 0x10FFFF
          len = $urandom_range(2, 4);
          send_item(rand_lead(len), 1'b0);
          for (int i = 1; i < len; i++) send_item(rand_cont(), 1'b0);
          cnt += len;
        end
        [70:79]: begin
          // sequence cut short by a non-continuation byte or end of text
          len = $urandom_range(2, 4);
          k   = $urandom_range(0, len - 2);
          send_item(rand_lead(len), 1'b0);
          for (int i = 0; i < k; i++) send_item(rand_cont(), 1'b0);
          if ($urandom_range(0, 1) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            send_item(b, 1'b0);
          end
          cnt += k + 2;
        end
        [80:91]: send_item(8'($urandom_range(0, 255)), 1'b0);
        default: begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
          cnt++;
        end
      endcase
    end
  endtask

  task automatic test_random_text();
    idle_pct  = 0;
    stall_pct = 0;
    random_text(50);
    idle_pct  = 76;
    stall_pct = 0;
    random_text(50);
    idle_pct  = 0;
    stall_pct = 76;
    random_text(50);
    idle_pct  = 11;
    stall_pct = 11;
    random_text(50);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.in_byte     <= 8'h00;
    in_if.end_of_text <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ascii_words();
    test_multibyte_chars();
    test_malformed_input();
    test_random_text();

    // Drain: let every predicted result arrive, then watch for extras
    in_if.valid <= 1'b0;
    stall_pct = 0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input items (directed words, multi-byte, malformed, random text)",
             items_sent);
    $display("under four pacing phases; %0d token results checked, %0d mismatches",
             res_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/utf8ws_pkg.sv
rtl/utf8ws_if.sv
rtl/utf8ws_decode.sv
rtl/utf8_word_splitter_core.sv
tb/tb_top.sv
